// ===== hw/rtl/lkvc_pkg.sv =====
// ============================================================================
// lkvc_pkg
// Shared widths, register map and word types of the LRU key/value cache.
// ============================================================================
`default_nettype none

package lkvc_pkg;

    localparam int KEY_BITS        = 32;
    localparam int VALUE_BITS      = 32;
    localparam int CAP_BITS        = 5;
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int APB_DATA_BITS   = 32;
    localparam int ADDR_BITS       = 3;
    localparam int REG_IDX_BITS    = ADDR_BITS - 2;

    localparam logic [CAP_BITS-1:0]     CAP_RESET    = CAP_BITS'(16);
    localparam logic [REG_IDX_BITS-1:0] REG_CAPACITY = REG_IDX_BITS'(0);

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic                  value_present;
    } t_in_word;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  read_present;
    } t_out_word;

    // one cache entry as it moves down the chain
    typedef struct packed {
        logic                  valid;
        logic                  present;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // lookup broadcast to every cell
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                full;
    } t_probe;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_key_value_cache.sv =====
// ============================================================================
// lru_key_value_cache
// Fully associative LRU key/value cache built as a recency-ordered cell chain.
// ============================================================================
// Usage:
//   Input words (get or put) arrive on i_in_valid/o_in_ready; one result word
//   per input leaves on o_out_valid/i_out_ready. The result of an accepted
//   word is registered at the accepting edge and shown from that edge on.
//   The cells form a row ordered by recency: cell 0 is the most recent entry.
//   Every cell compares the key in the same cycle; on a hit or an insert a
//   shift wave moves entries one cell down, from cell 0 up to the hit cell
//   (or the first free cell, or the last valid cell when full, which drops
//   the least recent entry), and the accessed entry lands in cell 0.
//   Throughput: one word per cycle while results are taken; the chain
//   compares and shifts straight into the cell registers, and the output
//   register lets a new word enter while the previous result is being taken.
//   When the receiver stalls, the result register holds and o_in_ready drops
//   until the result is taken.
//   Reset clears all valid bits, the entry count and the result valid flag,
//   and sets capacity to 16. The user writes capacity through the APB port
//   (register 0, byte address 0) only while idle; the block does not check.
// ============================================================================
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [lkvc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lkvc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lkvc_pkg::t_in_word                  i_in_word,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lkvc_pkg::t_out_word                 o_out_word
);
    import lkvc_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CAP_BITS-1:0] r_capacity;
    logic                w_cfg_sel;

    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[ADDR_BITS-1:2] == REG_CAPACITY);
    assign prdata    = w_cfg_sel ? APB_DATA_BITS'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && w_cfg_sel) begin
            r_capacity <= pwdata[CAP_BITS-1:0];
        end
    end

    // Clamp capacity into 1 .. MAX_ENTRIES.
    logic [CMP_W-1:0] w_cap_wide;
    logic [CMP_W-1:0] w_eff_cap;

    assign w_cap_wide = CMP_W'(r_capacity);

    always_comb begin
        if (w_cap_wide == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_wide > MAX_CMP) begin
            w_eff_cap = MAX_CMP;
        end else begin
            w_eff_cap = w_cap_wide;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and entry count
    // ------------------------------------------------------------------
    logic             r_out_valid;
    t_out_word        r_out_word;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;
    logic             w_full;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = CMP_W'(r_count) >= w_eff_cap;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    t_entry                 w_entry [MAX_ENTRIES];
    t_entry                 w_head;
    t_probe                 w_probe;
    logic [MAX_ENTRIES:0]   w_carry;
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_valid;
    logic                   w_hit;
    logic [VALUE_BITS-1:0]  w_hit_value;
    logic                   w_hit_present;
    logic                   w_is_put;

    assign w_is_put      = (i_in_word.command == CMD_PUT);
    assign w_probe.key   = i_in_word.key;
    assign w_probe.full  = w_full;
    assign w_hit         = |w_match;

    // Launch the shift wave on every put and on a get hit; a get miss
    // leaves the chain untouched.
    assign w_carry[0] = w_accept && (w_is_put || w_hit);

    // Select the hit entry; at most one cell matches.
    always_comb begin
        w_hit_value   = '0;
        w_hit_present = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit_value   = w_hit_value   | (w_entry[i].value & {VALUE_BITS{w_match[i]}});
            w_hit_present = w_hit_present | (w_entry[i].present & w_match[i]);
        end
    end

    // Entry that lands in cell 0: new data on a put, kept data on a get.
    assign w_head.valid   = 1'b1;
    assign w_head.key     = i_in_word.key;
    assign w_head.value   = w_is_put ? i_in_word.value : w_hit_value;
    assign w_head.present = w_is_put ? i_in_word.value_present : w_hit_present;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_entry w_left;
        logic   w_next_valid;

        if (g == 0) begin : g_first
            assign w_left = w_head;
        end else begin : g_rest
            assign w_left = w_entry[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
        end

        assign w_valid[g] = w_entry[g].valid;

        lkvc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_probe      (w_probe),
            .i_entry      (w_left),
            .i_carry      (w_carry[g]),
            .i_next_valid (w_next_valid),
            .o_entry      (w_entry[g]),
            .o_match      (w_match[g]),
            .o_carry      (w_carry[g+1])
        );
    end

    // Grow the count on an insert into a free cell; a full insert evicts.
    always_comb begin
        n_count = r_count;
        if (w_accept && w_is_put && !w_hit && !w_full) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word.hit          <= w_hit;
            r_out_word.read_value   <= w_is_put ? '0 : w_hit_value;
            r_out_word.read_present <= w_is_put ? 1'b0 : w_hit_present;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The shift wave always finds a stopping cell inside the chain.
    a_wave_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_carry[MAX_ENTRIES])
        else $error("shift wave ran off the end of the cell chain");

    // Keys are unique among valid cells.
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matched the key");

    // Valid cells track the entry count.
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("entry count disagrees with valid cells");

    // A put miss on a full cache keeps the count.
    a_evict_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_put && !w_hit && w_full) |=> $stable(r_count))
        else $error("eviction changed the entry count");

endmodule

`default_nettype wire

// ===== hw/rtl/lkvc_cell.sv =====
// ============================================================================
// lkvc_cell
// One recency slot: holds an entry, compares it against the probe key and
// loads its left neighbor's entry when the shift wave reaches it.
// ============================================================================
`default_nettype none

module lkvc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lkvc_pkg::t_probe i_probe,
    input  lkvc_pkg::t_entry i_entry,
    input  logic            i_carry,
    input  logic            i_next_valid,
    output lkvc_pkg::t_entry o_entry,
    output logic            o_match,
    output logic            o_carry
);
    import lkvc_pkg::*;

    logic                  r_valid;
    logic                  r_present;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  w_stop;

    assign o_match = r_valid && (r_key == i_probe.key);

    // stop the shift here: hit slot, first free slot, or last slot when full
    assign w_stop = o_match
                 || (!i_probe.full && !r_valid)
                 || (i_probe.full && r_valid && !i_next_valid);
    assign o_carry = i_carry && !w_stop;

    assign o_entry.valid   = r_valid;
    assign o_entry.present = r_present;
    assign o_entry.key     = r_key;
    assign o_entry.value   = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_carry) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_carry) begin
            r_present <= i_entry.present;
            r_key     <= i_entry.key;
            r_value   <= i_entry.value;
        end
    end

endmodule

`default_nettype wire
